// ===== rtl/sha256_hasher_defines.svh =====
// assertion helpers for the hasher
`ifndef SHA256_HASHER_DEFINES_SVH
`define SHA256_HASHER_DEFINES_SVH

// condition must never hold outside reset
`define SHAHS_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SHAHS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/shahs_pkg.sv =====
package shahs_pkg;

    // input beat
    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in;

    // result beat
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    localparam int IN_DEPTH_DEF  = 4;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

endpackage

// ===== rtl/sha256_hasher.sv =====
// channel  | dir | handshake           | beat
// ---------+-----+---------------------+-------------------------------------
// input    | in  | push / full         | i_item: byte, byte flag, end flag
// result   | out | pop / empty         | o_result: digest word, index, last
//
// the engine takes message bytes while idle; every full 64-byte block then runs
// 64 rounds on one shared round unit plus the chaining add, taking no bytes meanwhile
// end of message: padding fills one or two blocks, then 8 word beats
// reset is synchronous, active low, and restores the initial hash values
// an input queue and an output queue let each side stall independently
module sha256_hasher #(
    parameter int IN_DEPTH  = shahs_pkg::IN_DEPTH_DEF,
    parameter int OUT_DEPTH = shahs_pkg::OUT_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    output logic            full,
    input  shahs_pkg::t_in  i_item,
    input  logic            pop,
    output logic            empty,
    output shahs_pkg::t_out o_result
);
    import shahs_pkg::*;
    `include "sha256_hasher_defines.svh"

    t_in  f_item;
    logic f_empty, b_pop;
    logic b_push, res_full;
    t_out b_res;

    // classify and queue input beats
    shahs_front #(
        .DEPTH (IN_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_pop   (b_pop),
        .o_item  (f_item),
        .o_empty (f_empty)
    );

    // hashing engine
    shahs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (f_empty),
        .i_item  (f_item),
        .o_pop   (b_pop),
        .i_full  (res_full),
        .o_push  (b_push),
        .o_res   (b_res)
    );

    // result queue
    shahs_fifo #(
        .WIDTH ($bits(t_out)),
        .DEPTH (OUT_DEPTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_push),
        .i_data  (b_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

    `SHAHS_ASSERT_NEVER(a_pop_busy, b_pop && b_push, "engine took a beat while emitting")
    `SHAHS_ASSERT_IMPL(a_last_idx, !empty, o_result.last_word == (o_result.word_index == 3'd7), "last flag off index")
    `SHAHS_ASSERT_IMPL(a_pop_valid, b_pop, !f_empty, "engine popped an empty queue")
endmodule

// ===== rtl/shahs_fifo.sv =====
module shahs_fifo #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

// ===== rtl/shahs_front.sv =====
module shahs_front #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  shahs_pkg::t_in i_item,
    output logic           o_full,
    input  logic           i_pop,
    output shahs_pkg::t_in o_item,
    output logic           o_empty
);
    import shahs_pkg::*;

    logic q_push;
    logic q_full;
    t_in  q_out;

    // beats with neither byte nor end are taken and dropped
    assign q_push = i_push && (i_item.byte_present || i_item.end_of_message);
    assign o_full = q_full;
    assign o_item = q_out;

    shahs_fifo #(
        .WIDTH ($bits(t_in)),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (i_item),
        .o_full  (q_full),
        .i_pop   (i_pop),
        .o_data  (q_out),
        .o_empty (o_empty)
    );
endmodule

// ===== rtl/shahs_back.sv =====
module shahs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  shahs_pkg::t_in  i_item,
    output logic            o_pop,
    input  logic            i_full,
    output logic            o_push,
    output shahs_pkg::t_out o_res
);
    import shahs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [1:0] P_MARK = 2'd0;
    localparam logic [1:0] P_ZERO = 2'd1;
    localparam logic [1:0] P_LEN  = 2'd2;

    logic [2:0]   r_state, n_state;
    logic [511:0] r_blk, n_blk;
    logic [5:0]   r_pos, n_pos;
    logic [60:0]  r_cnt, n_cnt;
    logic [63:0]  r_bits, n_bits;
    logic         r_pad, n_pad;
    logic [1:0]   r_pst, n_pst;
    logic [2:0]   r_lidx, n_lidx;
    logic         r_last, n_last;
    logic [5:0]   r_rnd, n_rnd;
    logic [31:0]  r_v [8];
    logic [31:0]  n_v [8];
    logic [31:0]  r_h [8];
    logic [31:0]  n_h [8];
    logic [2:0]   r_oidx, n_oidx;

    logic         do_push;
    logic [7:0]   pb;
    logic [60:0]  cnt_inc;
    logic [31:0]  w0, w1, w9, w14, wnew, sg0, sg1;
    logic [31:0]  bs0, bs1, ch, mj, t1, t2;

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign o_push = (r_state == S_OUT);
    assign o_res  = '{digest_word: r_h[r_oidx], word_index: r_oidx,
                      last_word: (r_oidx == 3'd7)};

    // schedule window, oldest word at the top
    assign w0   = r_blk[511:480];
    assign w1   = r_blk[479:448];
    assign w9   = r_blk[223:192];
    assign w14  = r_blk[63:32];
    assign sg0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
    assign sg1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
    assign wnew = w0 + sg0 + w9 + sg1;

    // round function
    assign bs1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
               ^ {r_v[4][24:0], r_v[4][31:25]};
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1  = r_v[7] + bs1 + ch + K_TABLE[r_rnd] + w0;
    assign bs0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
               ^ {r_v[0][21:0], r_v[0][31:22]};
    assign mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2  = bs0 + mj;
    assign cnt_inc = r_cnt + 61'd1;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_blk   = r_blk;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_bits  = r_bits;
        n_pad   = r_pad;
        n_pst   = r_pst;
        n_lidx  = r_lidx;
        n_last  = r_last;
        n_rnd   = r_rnd;
        n_v     = r_v;
        n_h     = r_h;
        n_oidx  = r_oidx;
        do_push = 1'b0;
        pb      = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    if (i_item.byte_present) begin
                        do_push = 1'b1;
                        pb      = i_item.message_byte;
                        n_cnt   = cnt_inc;
                    end
                    if (i_item.end_of_message) begin
                        n_pad   = 1'b1;
                        n_pst   = P_MARK;
                        n_lidx  = '0;
                        n_state = S_PAD;
                        n_bits  = {(i_item.byte_present ? cnt_inc : r_cnt), 3'b000};
                    end
                end
            end
            S_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_blk  = {r_blk[479:0], wnew};
                n_rnd  = r_rnd + 1'b1;
                if (r_rnd == 6'd63) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_h[i] = r_h[i] + r_v[i];
                end
                n_state = r_last ? S_OUT : (r_pad ? S_PAD : S_IDLE);
            end
            S_PAD: begin
                case (r_pst)
                    P_MARK: begin
                        do_push = 1'b1;
                        pb      = PAD_MARK;
                        n_pst   = P_ZERO;
                    end
                    P_ZERO: begin
                        if (r_pos == LEN_OFFSET) begin
                            n_pst = P_LEN;
                        end else begin
                            do_push = 1'b1;
                        end
                    end
                    default: begin
                        do_push = 1'b1;
                        pb      = r_bits[63:56];
                        n_bits  = {r_bits[55:0], 8'h00};
                        n_lidx  = r_lidx + 1'b1;
                        if (r_lidx == 3'd7) begin
                            n_last = 1'b1;
                        end
                    end
                endcase
            end
            S_OUT: begin
                if (!i_full) begin
                    n_oidx = r_oidx + 1'b1;
                    if (r_oidx == 3'd7) begin
                        n_h     = H_INIT;
                        n_cnt   = '0;
                        n_pad   = 1'b0;
                        n_last  = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // byte into the block, full block starts the rounds
        if (do_push) begin
            n_blk = {r_blk[503:0], pb};
            n_pos = r_pos + 1'b1;
            if (r_pos == 6'd63) begin
                n_state = S_ROUND;
                n_rnd   = '0;
                n_v     = r_h;
            end
        end
    end

    // control and chain state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_pad   <= 1'b0;
            r_pst   <= P_MARK;
            r_lidx  <= '0;
            r_last  <= 1'b0;
            r_rnd   <= '0;
            r_oidx  <= '0;
            r_h     <= H_INIT;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_pad   <= n_pad;
            r_pst   <= n_pst;
            r_lidx  <= n_lidx;
            r_last  <= n_last;
            r_rnd   <= n_rnd;
            r_oidx  <= n_oidx;
            r_h     <= n_h;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_bits <= n_bits;
        r_v    <= n_v;
    end
endmodule
